FILE: hdl/tmf_pkg.sv
package tmf_pkg;

  localparam int unsigned MaxTilesDef = 256;
  localparam int unsigned MaxRowsDef  = 16;
  localparam int unsigned CfgAddrW    = 2;
  localparam int unsigned CfgDataW    = 8;
  localparam int unsigned PropsW      = 8;
  localparam int unsigned RowPixW     = 64;
  localparam int unsigned PalW        = 3;
  localparam int unsigned RowsCfgW    = 5;
  localparam int unsigned NumOrient   = 4;

  localparam logic [PropsW-1:0] BitMirror  = 8'h20;
  localparam logic [PropsW-1:0] BitReverse = 8'h40;

  localparam logic [CfgAddrW-1:0] RegDefaultProps = 2'd0;
  localparam logic [CfgAddrW-1:0] RegFlipEnable   = 2'd1;
  localparam logic [CfgAddrW-1:0] RegRowsPerTile  = 2'd2;

  typedef enum logic [1:0] {
    CmdLoad   = 2'd0,
    CmdSearch = 2'd1,
    CmdAppend = 2'd2,
    CmdClear  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    StIdle,
    StSearch,
    StAppend,
    StDone
  } state_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [3:0]  row_index;
    logic [63:0] row_pixels;
    logic [2:0]  palette;
  } in_item_t;

  typedef struct packed {
    logic       found;
    logic [7:0] tile_index;
    logic [7:0] props;
    logic       status;
  } out_item_t;

  // lane control from the sequencer
  typedef struct packed {
    logic clr;  // start of a tile
    logic en;   // row beat valid
  } lane_ctl_t;

  function automatic logic [RowPixW-1:0] mirror_row(input logic [RowPixW-1:0] v);
    logic [RowPixW-1:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      r[8*i +: 8] = v[8*(7-i) +: 8];
    end
    return r;
  endfunction

endpackage

FILE: hdl/tmf_lane.sv
// one orientation compare lane: accumulates row equality over a tile
module tmf_lane (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tmf_pkg::lane_ctl_t           ctl_i,
  input  logic [tmf_pkg::RowPixW-1:0]  stored_i,
  input  logic [tmf_pkg::RowPixW-1:0]  query_i,
  input  logic                         pal_eq_i,
  output logic                         match_o
);

  logic eq_q, eq_d;

  // running match flag, restarted at each tile
  always_comb begin
    if (ctl_i.clr) begin
      eq_d = pal_eq_i & (stored_i == query_i);
    end else if (ctl_i.en) begin
      eq_d = eq_q & (stored_i == query_i);
    end else begin
      eq_d = eq_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eq_q <= 1'b0;
    end else begin
      eq_q <= eq_d;
    end
  end

  assign match_o = eq_q;

endmodule

FILE: hdl/tmf_merge.sv
// merge: keeps, per orientation, the index of the first tile that hit
module tmf_merge #(
  parameter int unsigned MaxTiles = tmf_pkg::MaxTilesDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                clr_i,
  input  logic                                tile_end_i,
  input  logic [$clog2(MaxTiles+1)-1:0]       tile_i,
  input  logic [tmf_pkg::NumOrient-1:0]       hit_i,
  output logic [tmf_pkg::NumOrient-1:0]       have_o,
  output logic [tmf_pkg::NumOrient*8-1:0]     idx_o
);

  logic [tmf_pkg::NumOrient-1:0] have_q, have_d;
  logic [7:0]                    idx_q [tmf_pkg::NumOrient];

  // first tile index per orientation, lowest index wins
  always_comb begin
    have_d = have_q;
    if (clr_i) begin
      have_d = '0;
    end else if (tile_end_i) begin
      have_d = have_q | hit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= '0;
    end else begin
      have_q <= have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int o = 0; o < tmf_pkg::NumOrient; o++) begin
      if (tile_end_i && hit_i[o] && !have_q[o]) begin
        idx_q[o] <= 8'(tile_i);
      end
    end
  end

  always_comb begin
    for (int o = 0; o < tmf_pkg::NumOrient; o++) begin
      idx_o[8*o +: 8] = idx_q[o];
    end
  end

  assign have_o = have_q;

endmodule

FILE: hdl/tile_match_with_flips.sv
// search: one stored row per cycle, all four orientations in parallel lanes.
// append copies MAX_ROWS query rows one per cycle; refused with status when full.
// load and clear give no result; one item at a time.
// reset clears state, count, query palette; sets 8 rows per tile; stores unset.
// results are a one-cycle strobe; the receiver cannot stall.
module tile_match_with_flips #(
  parameter int unsigned MaxTiles = tmf_pkg::MaxTilesDef,
  parameter int unsigned MaxRows  = tmf_pkg::MaxRowsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  tmf_pkg::in_item_t              in_i,
  output logic                           done,
  output tmf_pkg::out_item_t             out_o,
  input  logic                           cfg_we_i,
  input  logic [tmf_pkg::CfgAddrW-1:0]   cfg_idx_i,
  input  logic [tmf_pkg::CfgDataW-1:0]   cfg_data_i
);

  localparam int unsigned RW  = (MaxRows > 1) ? $clog2(MaxRows) : 1;
  localparam int unsigned TW  = (MaxTiles > 1) ? $clog2(MaxTiles) : 1;
  localparam int unsigned CW  = $clog2(MaxTiles+1);
  localparam int unsigned AW  = TW + RW;
  localparam int unsigned Depth = MaxTiles * (1 << RW);

  // configuration registers
  logic [7:0] props_q;
  logic       flip_q;
  logic [4:0] rows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      props_q <= '0;
      flip_q  <= 1'b0;
      rows_q  <= 5'd8;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tmf_pkg::RegDefaultProps: props_q <= cfg_data_i;
        tmf_pkg::RegFlipEnable:   flip_q  <= cfg_data_i[0];
        tmf_pkg::RegRowsPerTile:  rows_q  <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // active row count, clamped to 1..MaxRows
  logic [5:0] nrows_w;
  always_comb begin
    if (rows_q == '0) begin
      nrows_w = 6'd1;
    end else if (32'(rows_q) > MaxRows) begin
      nrows_w = 6'(MaxRows);
    end else begin
      nrows_w = {1'b0, rows_q};
    end
  end

  // query rows, held in flops and read at fixed and reversed places
  logic [63:0] qrow_q [MaxRows];
  logic [2:0]  qpal_q;
  logic        acc_w;
  assign acc_w = start & ~busy;

  always_ff @(posedge clk_i) begin
    if (acc_w && in_i.command == tmf_pkg::CmdLoad && 32'(in_i.row_index) < MaxRows) begin
      qrow_q[in_i.row_index[RW-1:0]] <= in_i.row_pixels;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qpal_q <= '0;
    end else if (acc_w && in_i.command == tmf_pkg::CmdLoad &&
                 32'(in_i.row_index) < MaxRows) begin
      qpal_q <= in_i.palette;
    end
  end

  // sequencer state
  tmf_pkg::state_e st_q, st_d;
  logic [CW-1:0]   cnt_q, cnt_d;     // tile count
  logic [CW-1:0]   t_q, t_d;         // tile under scan
  logic [RW:0]     r_q, r_d;         // row under scan / copy
  logic            last_q, last_d;   // last read beat issued
  tmf_pkg::out_item_t res_q, res_d;
  logic            done_q, done_d;

  // table memories
  logic [63:0] trow_mem [Depth];
  logic [2:0]  tpal_mem [MaxTiles];
  logic [63:0] rd_row_q;
  logic [2:0]  rd_pal_q;
  logic        rd_vld_q, rd_first_q, rd_lastrow_q;
  logic [RW-1:0] rd_r_q;
  logic [CW-1:0] rd_t_q;

  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  assign wr_en   = (st_q == tmf_pkg::StAppend) && !r_q[RW];
  assign wr_addr = {t_q[TW-1:0], r_q[RW-1:0]};
  assign rd_addr = {t_q[TW-1:0], r_q[RW-1:0]};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      trow_mem[wr_addr] <= qrow_q[r_q[RW-1:0]];
    end
    rd_row_q <= trow_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en && r_q == '0) begin
      tpal_mem[t_q[TW-1:0]] <= qpal_q;
    end
    rd_pal_q <= tpal_mem[t_q[TW-1:0]];
  end

  logic scan_beat;
  assign scan_beat = (st_q == tmf_pkg::StSearch) && !last_q;

  // read beat tags line up with the registered memory data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q     <= 1'b0;
      rd_first_q   <= 1'b0;
      rd_lastrow_q <= 1'b0;
      rd_r_q       <= '0;
      rd_t_q       <= '0;
    end else begin
      rd_vld_q     <= scan_beat;
      rd_first_q   <= scan_beat && r_q == '0;
      rd_lastrow_q <= scan_beat && (r_q + 1'b1) == nrows_w[RW:0];
      rd_r_q       <= r_q[RW-1:0];
      rd_t_q       <= t_q;
    end
  end

  // orientation lanes
  logic [RW-1:0] rev_r;
  assign rev_r = RW'(nrows_w - 6'd1 - 6'(rd_r_q));

  logic [63:0] q_lane [tmf_pkg::NumOrient];
  always_comb begin
    q_lane[0] = qrow_q[rd_r_q];
    q_lane[1] = tmf_pkg::mirror_row(qrow_q[rd_r_q]);
    q_lane[2] = tmf_pkg::mirror_row(qrow_q[rev_r]);
    q_lane[3] = qrow_q[rev_r];
  end

  tmf_pkg::lane_ctl_t lctl;
  assign lctl.clr = rd_vld_q & rd_first_q;
  assign lctl.en  = rd_vld_q;

  logic [tmf_pkg::NumOrient-1:0] hit_w;
  for (genvar o = 0; o < tmf_pkg::NumOrient; o++) begin : g_lane
    tmf_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (lctl),
      .stored_i (rd_row_q),
      .query_i  (q_lane[o]),
      .pal_eq_i (rd_pal_q == qpal_q),
      .match_o  (hit_w[o])
    );
  end

  // lane result valid the cycle after the last row beat
  logic tend_q;
  logic [CW-1:0] tend_t_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tend_q   <= 1'b0;
      tend_t_q <= '0;
    end else begin
      tend_q   <= rd_vld_q & rd_lastrow_q;
      tend_t_q <= rd_t_q;
    end
  end

  logic [tmf_pkg::NumOrient-1:0]   have_w;
  logic [tmf_pkg::NumOrient*8-1:0] idx_w;
  logic                            mclr;
  assign mclr = acc_w;

  tmf_merge #(.MaxTiles(MaxTiles)) u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clr_i      (mclr),
    .tile_end_i (tend_q),
    .tile_i     (tend_t_q),
    .hit_i      (hit_w),
    .have_o     (have_w),
    .idx_o      (idx_w)
  );

  // drain: memory, lane, merge stages after the last read
  logic [1:0] drain_q, drain_d;

  // next state
  always_comb begin
    st_d    = st_q;
    cnt_d   = cnt_q;
    t_d     = t_q;
    r_d     = r_q;
    last_d  = last_q;
    drain_d = drain_q;
    case (st_q)
      tmf_pkg::StIdle: begin
        if (acc_w) begin
          t_d = '0;
          r_d = '0;
          case (in_i.command)
            tmf_pkg::CmdSearch: begin
              st_d    = tmf_pkg::StSearch;
              last_d  = (cnt_q == '0);
              drain_d = 2'd3;
            end
            tmf_pkg::CmdAppend: begin
              st_d = (32'(cnt_q) >= MaxTiles) ? tmf_pkg::StDone : tmf_pkg::StAppend;
              t_d  = cnt_q;
            end
            tmf_pkg::CmdClear: cnt_d = '0;
            default: ;
          endcase
        end
      end
      tmf_pkg::StSearch: begin
        if (!last_q) begin
          if ((r_q + 1'b1) == nrows_w[RW:0]) begin
            r_d = '0;
            t_d = t_q + 1'b1;
            if ((t_q + 1'b1) == cnt_q) begin
              last_d = 1'b1;
            end
          end else begin
            r_d = r_q + 1'b1;
          end
        end else if (drain_q == '0) begin
          st_d = tmf_pkg::StDone;
        end else begin
          drain_d = drain_q - 2'd1;
        end
      end
      tmf_pkg::StAppend: begin
        if (32'(r_q) == MaxRows - 1) begin
          st_d  = tmf_pkg::StDone;
          cnt_d = cnt_q + 1'b1;
        end
        r_d = r_q + 1'b1;
      end
      tmf_pkg::StDone: st_d = tmf_pkg::StIdle;
      default: st_d = tmf_pkg::StIdle;
    endcase
  end

  // result forming
  always_comb begin
    res_d  = res_q;
    done_d = 1'b0;
    case (st_q)
      tmf_pkg::StIdle: begin
        if (acc_w && in_i.command == tmf_pkg::CmdAppend) begin
          res_d = '0;
          if (32'(cnt_q) >= MaxTiles) begin
            res_d.status = 1'b1;
          end else begin
            res_d.tile_index = 8'(cnt_q);
          end
        end
        if (acc_w && in_i.command == tmf_pkg::CmdSearch) begin
          res_d = '0;
        end
      end
      tmf_pkg::StSearch: begin
        if (last_q && drain_q == '0) begin
          if (have_w[0]) begin
            res_d = '{1'b1, idx_w[7:0], props_q, 1'b0};
          end else if (flip_q && have_w[1]) begin
            res_d = '{1'b1, idx_w[15:8], props_q | tmf_pkg::BitMirror, 1'b0};
          end else if (flip_q && have_w[2]) begin
            res_d = '{1'b1, idx_w[23:16],
                      props_q | tmf_pkg::BitMirror | tmf_pkg::BitReverse, 1'b0};
          end else if (flip_q && have_w[3]) begin
            res_d = '{1'b1, idx_w[31:24], props_q | tmf_pkg::BitReverse, 1'b0};
          end else begin
            res_d = '0;
          end
        end
      end
      tmf_pkg::StDone: done_d = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= tmf_pkg::StIdle;
      cnt_q   <= '0;
      t_q     <= '0;
      r_q     <= '0;
      last_q  <= 1'b0;
      drain_q <= '0;
      done_q  <= 1'b0;
    end else begin
      st_q    <= st_d;
      cnt_q   <= cnt_d;
      t_q     <= t_d;
      r_q     <= r_d;
      last_q  <= last_d;
      drain_q <= drain_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign busy  = (st_q != tmf_pkg::StIdle) || done_q;
  assign done  = done_q;
  assign out_o = res_q;

endmodule

FILE: hdl/tmf_checker.sv
// port-level checks on the command handshake and result beats
module tmf_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               busy,
  input logic               done,
  input tmf_pkg::out_item_t out_o
);

  // a result beat lasts exactly one cycle
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> !done) else $error("result beat longer than one cycle");

  // the block stays busy while a result beat is shown
  a_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> busy) else $error("result beat while idle");

  // refused append carries no match
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done && out_o.status) |-> !out_o.found && out_o.tile_index == '0)
    else $error("refused append with payload");

  // a result without a match carries zero props
  a_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done && !out_o.found) |-> out_o.props == '0)
    else $error("props set without match");

endmodule

bind tile_match_with_flips tmf_checker u_tmf_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .busy   (busy),
  .done   (done),
  .out_o  (out_o)
);
